FILE: src/vlsc_pkg.sv
// Package with the shared types, codes and constants of the lamp strip controller.
`default_nettype none

package vlsc_pkg;

    // Pixel index bits that a query uses; the port field itself is 8 bits wide.
    localparam int INDEX_BITS = 8;
    localparam logic [7:0] IDX_MASK = 8'((33'd1 << INDEX_BITS) - 33'd1);

    // Colors as 0xRRGGBB.
    localparam logic [23:0] COL_AMBER   = 24'hFFBF00;
    localparam logic [23:0] COL_WHITE   = 24'hFFFFFF;
    localparam logic [23:0] COL_BLACK   = 24'h000000;
    localparam logic [23:0] COL_RED     = 24'hFF0000;
    localparam logic [23:0] COL_DARKRED = 24'hCC0000;

    // Blink timing in milliseconds.
    localparam logic [9:0] HALF_PERIOD = 10'd500;
    localparam logic [9:0] FULL_PERIOD = 10'd1000;

    // Item actions.
    typedef enum logic [2:0] {
        ACT_SIDE  = 3'd0,
        ACT_LOW   = 3'd1,
        ACT_HIGH  = 3'd2,
        ACT_HAZ   = 3'd3,
        ACT_LEFT  = 3'd4,
        ACT_RIGHT = 3'd5,
        ACT_FRONT = 3'd6,
        ACT_REAR  = 3'd7
    } t_action;

    // Lamp modes; bit 1 set means toggle.
    localparam logic [1:0] MODE_ON = 2'd1;
    localparam int MODE_TOGGLE_BIT = 1;

    // Flag bit positions.
    localparam int FLG_SIDE  = 0;
    localparam int FLG_LOW   = 1;
    localparam int FLG_HIGH  = 2;
    localparam int FLG_HAZ   = 3;
    localparam int FLG_LEFT  = 4;
    localparam int FLG_RIGHT = 5;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_FRONT_STRIP = 2'd0,
        CFG_FRONT_SIDE  = 2'd1,
        CFG_REAR_STRIP  = 2'd2,
        CFG_REAR_SIDE   = 2'd3
    } t_cfg_idx;

    // Strip geometry.
    typedef struct packed {
        logic [7:0] front_strip_length;
        logic [6:0] front_side_length;
        logic [7:0] rear_strip_length;
        logic [6:0] rear_side_length;
    } t_cfg;

    typedef logic [5:0] t_flags;

endpackage

`default_nettype wire

FILE: src/vlsc_in_if.sv
// Input channel of the lamp strip controller: handshake and item fields.
`default_nettype none

interface vlsc_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [1:0] lamp_mode;
    logic [7:0] pixel_index;
    logic [9:0] phase_ms;
    logic       brake_active;

    modport source (
        output valid, action, lamp_mode, pixel_index, phase_ms, brake_active,
        input  ready
    );
    modport sink (
        input  valid, action, lamp_mode, pixel_index, phase_ms, brake_active,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/vlsc_out_if.sv
// Output channel of the lamp strip controller: handshake and result fields.
`default_nettype none

interface vlsc_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] pixel_color;
    logic [5:0]  lamp_flags;

    modport source (
        output valid, pixel_color, lamp_flags,
        input  ready
    );
    modport sink (
        input  valid, pixel_color, lamp_flags,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/vlsc_cfg_regs.sv
// Strip geometry registers written through the configuration port.
`default_nettype none

module vlsc_cfg_regs
    import vlsc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    output t_cfg            o_cfg
);

    t_cfg r_cfg;

    // Register write by index; all lengths clear at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FRONT_STRIP: r_cfg.front_strip_length <= i_cfg_data;
                CFG_FRONT_SIDE:  r_cfg.front_side_length  <= i_cfg_data[6:0];
                CFG_REAR_STRIP:  r_cfg.rear_strip_length  <= i_cfg_data;
                CFG_REAR_SIDE:   r_cfg.rear_side_length   <= i_cfg_data[6:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: src/vlsc_lamp_ctrl.sv
// Lamp flag register with the interlocks between the six lamps.
`default_nettype none

module vlsc_lamp_ctrl
    import vlsc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_advance,
    input  wire logic [2:0] i_action,
    input  wire logic [1:0] i_lamp_mode,
    output t_flags          o_flags,
    output t_flags          o_flags_next
);

    t_flags r_flags;
    t_flags n_flags;
    logic   cur;
    logic   en;

    // Next flags for the item in the compute stage.
    always_comb begin
        n_flags = r_flags;
        cur     = 1'b0;
        unique case (t_action'(i_action))
            ACT_SIDE:  cur = r_flags[FLG_SIDE];
            ACT_LOW:   cur = r_flags[FLG_LOW];
            ACT_HIGH:  cur = r_flags[FLG_HIGH];
            ACT_HAZ:   cur = r_flags[FLG_HAZ];
            ACT_LEFT:  cur = r_flags[FLG_LEFT];
            ACT_RIGHT: cur = r_flags[FLG_RIGHT];
            ACT_FRONT: cur = 1'b0;
            ACT_REAR:  cur = 1'b0;
        endcase
        en = i_lamp_mode[MODE_TOGGLE_BIT] ? !cur : (i_lamp_mode == MODE_ON);

        unique case (t_action'(i_action))
            ACT_SIDE: begin
                // Side lights stay on while either beam is on.
                if (en) begin
                    n_flags[FLG_SIDE] = 1'b1;
                end else if (!r_flags[FLG_HIGH] && !r_flags[FLG_LOW]) begin
                    n_flags[FLG_SIDE] = 1'b0;
                end
            end
            ACT_LOW: begin
                // Low beam stays on while high beam is on.
                if (en) begin
                    n_flags[FLG_LOW] = 1'b1;
                end else if (!r_flags[FLG_HIGH]) begin
                    n_flags[FLG_LOW] = 1'b0;
                end
            end
            ACT_HIGH: begin
                n_flags[FLG_HIGH] = en;
            end
            ACT_HAZ: begin
                // Switching hazard on clears both turns.
                if (en && !r_flags[FLG_HAZ]) begin
                    n_flags[FLG_LEFT]  = 1'b0;
                    n_flags[FLG_RIGHT] = 1'b0;
                end
                n_flags[FLG_HAZ] = en;
            end
            ACT_LEFT: begin
                if (!r_flags[FLG_HAZ]) begin
                    if (en) begin
                        n_flags[FLG_RIGHT] = 1'b0;
                    end
                    n_flags[FLG_LEFT] = en;
                end
            end
            ACT_RIGHT: begin
                if (!r_flags[FLG_HAZ]) begin
                    if (en) begin
                        n_flags[FLG_LEFT] = 1'b0;
                    end
                    n_flags[FLG_RIGHT] = en;
                end
            end
            ACT_FRONT: begin
                n_flags = r_flags;
            end
            ACT_REAR: begin
                n_flags = r_flags;
            end
        endcase
    end

    // Flags change only when the item leaves the compute stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_advance) begin
            r_flags <= n_flags;
        end
    end

    assign o_flags      = r_flags;
    assign o_flags_next = n_flags;

    // At most one turn lamp is on at any time.
    a_one_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_flags[FLG_LEFT], r_flags[FLG_RIGHT]}))
        else $error("both turn flags set");

    // While hazard is on, no turn flag is set.
    a_haz_no_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags[FLG_HAZ] |-> !r_flags[FLG_LEFT] && !r_flags[FLG_RIGHT])
        else $error("turn flag set during hazard");

    // A pixel query leaves the flags as they were.
    a_query_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && (i_action == ACT_FRONT || i_action == ACT_REAR)
        |=> r_flags == $past(r_flags))
        else $error("pixel query changed flags");

endmodule

`default_nettype wire

FILE: src/vlsc_pixel_color.sv
// Zone decode, turn sweep and color choice for one pixel query.
`default_nettype none

module vlsc_pixel_color
    import vlsc_pkg::*;
(
    input  wire t_cfg        i_cfg,
    input  wire t_flags      i_flags,
    input  wire logic        i_rear,
    input  wire logic [7:0]  i_pixel_index,
    input  wire logic [9:0]  i_phase_ms,
    input  wire logic        i_brake_active,
    output logic      [23:0] o_color
);

    logic        [7:0]  strip_len;
    logic        [6:0]  s_len;
    logic        [7:0]  idx;
    logic signed [9:0]  offset;
    logic signed [9:0]  idx_s;
    logic        [9:0]  phase;
    logic               phase_lo;
    logic        [15:0] prod;
    logic        [6:0]  k_left;
    logic        [9:0]  d_wide;
    logic        [8:0]  d_right;
    logic        [15:0] thr_left;
    logic        [17:0] thr_right;
    logic               in_left;
    logic               in_centre;
    logic               in_right;
    logic               amber_left;
    logic               amber_right;
    logic        [23:0] lit;
    logic        [23:0] base;

    // Zone bounds of the selected strip.
    always_comb begin
        strip_len = i_rear ? i_cfg.rear_strip_length : i_cfg.front_strip_length;
        s_len     = i_rear ? i_cfg.rear_side_length  : i_cfg.front_side_length;
        idx       = i_pixel_index & IDX_MASK;
        offset    = $signed({2'b00, strip_len}) - $signed({3'b000, s_len});
        idx_s     = $signed({2'b00, idx});
        in_left   = idx < {1'b0, s_len};
        in_centre = !in_left && (idx_s < offset);
        in_right  = idx_s >= offset;
    end

    // Sweep: step = floor(phase * s / 500) + 1, compared without a divide.
    // Left lit when phase*s >= 500*(s-i-1), right lit when 500*(i-offset) <= phase*s.
    always_comb begin
        phase     = (i_phase_ms >= FULL_PERIOD) ? i_phase_ms - FULL_PERIOD : i_phase_ms;
        phase_lo  = phase < HALF_PERIOD;
        prod      = 16'(phase[8:0]) * 16'(s_len);
        k_left    = s_len - idx[6:0] - 7'd1;
        d_wide    = {2'b00, idx} + {3'b000, s_len} - {2'b00, strip_len};
        d_right   = d_wide[8:0];
        thr_left  = 16'(k_left) * 16'(HALF_PERIOD);
        thr_right = 18'(d_right) * 18'(HALF_PERIOD);
        amber_left  = phase_lo && (prod >= thr_left);
        amber_right = phase_lo && ({2'b00, prod} >= thr_right);
    end

    // Color by zone; the left zone wins where the side zones overlap.
    always_comb begin
        lit  = i_rear ? COL_DARKRED : COL_WHITE;
        base = i_flags[FLG_SIDE] ? lit : COL_BLACK;
        priority if (in_centre) begin
            o_color = base;
        end else if (in_left) begin
            if (i_flags[FLG_LEFT] || i_flags[FLG_HAZ]) begin
                o_color = amber_left ? COL_AMBER : COL_BLACK;
            end else if (i_rear && i_brake_active) begin
                o_color = COL_RED;
            end else begin
                o_color = base;
            end
        end else if (in_right) begin
            if (i_flags[FLG_RIGHT] || i_flags[FLG_HAZ]) begin
                o_color = amber_right ? COL_AMBER : COL_BLACK;
            end else if (i_rear) begin
                o_color = (i_flags[FLG_SIDE] || i_flags[FLG_LOW] || i_flags[FLG_HIGH])
                          ? COL_RED : COL_BLACK;
            end else begin
                o_color = base;
            end
        end else begin
            o_color = COL_BLACK;
        end
    end

endmodule

`default_nettype wire

FILE: src/vehicle_lamp_strip_controller_unit.sv
// Top level of the vehicle lamp strip controller: input register, compute stage, result register.
//
// Use: items arrive on i_item (valid/ready). An item is a lamp command
// (side lights, low beam, high beam, hazard, left or right turn with set off,
// set on or toggle) or a front or rear pixel query. Each item gives exactly
// one result on o_result: the RGB color (zero for lamp commands) and the six
// lamp flags after the item.
// An item's transfer loads it into the input register; once the result register is
// free, the item is carried through zone decode, sweep compare and flag update
// into the result register.
// Throughput: one item per cycle while the receiver takes results, set by the
// single compute stage, whose longest path is one 9 by 7 bit multiply and a compare.
// Strip geometry is written through i_cfg_we/i_cfg_index/i_cfg_data; the user
// must write it only while no item is in flight, as the block does not enforce it.
// Reset (i_rst_n low, synchronous) clears the lamp flags, the geometry and
// both stage valid bits.
// When the receiver stalls, the result register holds its item, the input
// register fills, and i_item.ready then drops until the result is taken.
`default_nettype none

module vehicle_lamp_strip_controller_unit
    import vlsc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    vlsc_in_if.sink         i_item,
    vlsc_out_if.source      o_result,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    t_cfg        cfg;
    t_flags      flags;
    t_flags      flags_next;
    logic [23:0] color;
    logic        is_query;
    logic        advance;

    logic        r_in_valid;
    logic [2:0]  r_in_action;
    logic [1:0]  r_in_lamp_mode;
    logic [7:0]  r_in_pixel_index;
    logic [9:0]  r_in_phase_ms;
    logic        r_in_brake_active;

    logic        r_out_valid;
    logic [23:0] r_out_color;
    t_flags      r_out_flags;

    vlsc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Stage handshake: the compute stage moves when the result register is free.
    assign advance       = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready  = !r_in_valid || !r_out_valid || o_result.ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_action       <= i_item.action;
            r_in_lamp_mode    <= i_item.lamp_mode;
            r_in_pixel_index  <= i_item.pixel_index;
            r_in_phase_ms     <= i_item.phase_ms;
            r_in_brake_active <= i_item.brake_active;
        end
    end

    vlsc_lamp_ctrl u_lamp_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_action     (r_in_action),
        .i_lamp_mode  (r_in_lamp_mode),
        .o_flags      (flags),
        .o_flags_next (flags_next)
    );

    vlsc_pixel_color u_pixel_color (
        .i_cfg          (cfg),
        .i_flags        (flags),
        .i_rear         (r_in_action == ACT_REAR),
        .i_pixel_index  (r_in_pixel_index),
        .i_phase_ms     (r_in_phase_ms),
        .i_brake_active (r_in_brake_active),
        .o_color        (color)
    );

    assign is_query = (r_in_action == ACT_FRONT) || (r_in_action == ACT_REAR);

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_color <= is_query ? color : COL_BLACK;
            r_out_flags <= flags_next;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.pixel_color = r_out_color;
    assign o_result.lamp_flags  = r_out_flags;

    // Nothing is valid right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_valid && !r_out_valid)
        else $error("stage valid after reset");

    // An empty result register never blocks the input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_item.ready)
        else $error("input stalled with empty result register");

    // A held item in the input register stays until it can move on.
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid)
        else $error("input item lost while stalled");

    // A result that leaves the compute stage is shown in the next cycle.
    a_advance_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid && r_out_flags == $past(flags_next))
        else $error("result register missed an item");

endmodule

`default_nettype wire
